[rtl/v4alu_pkg.sv]
// ----------------------------------------------------------------------------
// v4alu_pkg
// Shared types and constants for the four-component fixed-point vector unit.
// ----------------------------------------------------------------------------
package v4alu_pkg;

    localparam int CW    = 32;
    localparam int FB    = 16;
    localparam int SQ_W  = CW + 1;
    localparam int RAD_W = 2 * SQ_W;
    localparam int Q_W   = FB + 1;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_SCALE  = 3'd2,
        OP_DOT    = 3'd3,
        OP_CROSS  = 3'd4,
        OP_LENGTH = 3'd5,
        OP_NORM   = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0]           operation;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] a_w;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] b_w;
        logic signed [CW-1:0] scale_factor;
    } t_req;

    typedef struct packed {
        logic signed [CW-1:0] r_x;
        logic signed [CW-1:0] r_y;
        logic signed [CW-1:0] r_z;
        logic signed [CW-1:0] r_w;
        logic signed [CW-1:0] scalar_result;
        logic                 saturated;
        logic                 zero_length;
    } t_res;

    typedef struct packed {
        logic [2:0]           op;
        logic [3:0]           a_neg;
        logic [3:0][CW-1:0]   a_mag;
        t_res                 res;
    } t_pass;

endpackage

[rtl/v4alu_front.sv]
// ----------------------------------------------------------------------------
// v4alu_front
// Operand select, six multipliers, product sums and truncate/clamp of the
// add, subtract, scale, dot and cross results. Five register stages.
// ----------------------------------------------------------------------------
module v4alu_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  v4alu_pkg::t_req                      i_req,
    output logic                                 o_vld,
    output v4alu_pkg::t_pass                     o_pass,
    output logic [v4alu_pkg::RAD_W-1:0]          o_rad
);

    localparam int CW = v4alu_pkg::CW;
    localparam int FB = v4alu_pkg::FB;
    localparam int PW = 2 * CW;

    function automatic logic [CW:0] trunc_sat(input logic signed [PW+1:0] x);
        logic            neg;
        logic [PW+1:0]   mag;
        logic [PW+1:0]   sh;
        logic [PW+1:0]   lim;
        logic            sat;
        logic [CW-1:0]   m;
        logic [CW-1:0]   v;
        neg = x[PW+1];
        mag = neg ? (PW+2)'(-x) : (PW+2)'(x);
        sh  = mag >> FB;
        lim = neg ? ((PW+2)'(1) << (CW-1)) : (((PW+2)'(1) << (CW-1)) - 1'b1);
        sat = sh > lim;
        m   = sat ? lim[CW-1:0] : sh[CW-1:0];
        v   = neg ? -m : m;
        return {sat, v};
    endfunction

    logic signed [CW-1:0] a [4];
    logic signed [CW-1:0] b [4];

    assign a[0] = i_req.a_x;
    assign a[1] = i_req.a_y;
    assign a[2] = i_req.a_z;
    assign a[3] = i_req.a_w;
    assign b[0] = i_req.b_x;
    assign b[1] = i_req.b_y;
    assign b[2] = i_req.b_z;
    assign b[3] = i_req.b_w;

    // stage 1
    logic signed [CW-1:0] n1_vec  [4];
    logic [3:0]           n1_vsat;
    logic signed [CW-1:0] n1_ma   [6];
    logic signed [CW-1:0] n1_mb   [6];
    logic [3:0]           n1_neg;
    logic [3:0][CW-1:0]   n1_mag;

    logic                 r1_vld;
    logic [2:0]           r1_op;
    logic signed [CW-1:0] r1_vec  [4];
    logic [3:0]           r1_vsat;
    logic signed [CW-1:0] r1_ma   [6];
    logic signed [CW-1:0] r1_mb   [6];
    logic [3:0]           r1_neg;
    logic [3:0][CW-1:0]   r1_mag;

    always_comb begin
        logic signed [CW:0] s;
        logic [CW-1:0]      au;
        for (int i = 0; i < 4; i++) begin
            if (i_req.operation == v4alu_pkg::OP_SUB) begin
                s = (CW+1)'(a[i]) - (CW+1)'(b[i]);
            end else begin
                s = (CW+1)'(a[i]) + (CW+1)'(b[i]);
            end
            n1_vsat[i] = s[CW] != s[CW-1];
            if (n1_vsat[i]) begin
                n1_vec[i] = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            end else begin
                n1_vec[i] = s[CW-1:0];
            end
            au        = a[i];
            n1_neg[i] = au[CW-1];
            n1_mag[i] = au[CW-1] ? (~au + 1'b1) : au;
        end
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n1_ma[i] = '0;
            n1_mb[i] = '0;
        end
        unique case (i_req.operation)
            v4alu_pkg::OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    n1_ma[i] = a[i];
                    n1_mb[i] = i_req.scale_factor;
                end
            end
            v4alu_pkg::OP_DOT: begin
                for (int i = 0; i < 4; i++) begin
                    n1_ma[i] = a[i];
                    n1_mb[i] = b[i];
                end
            end
            v4alu_pkg::OP_LENGTH, v4alu_pkg::OP_NORM: begin
                for (int i = 0; i < 4; i++) begin
                    n1_ma[i] = a[i];
                    n1_mb[i] = a[i];
                end
            end
            v4alu_pkg::OP_CROSS: begin
                n1_ma[0] = a[1]; n1_mb[0] = b[2];
                n1_ma[1] = a[2]; n1_mb[1] = b[0];
                n1_ma[2] = a[0]; n1_mb[2] = b[1];
                n1_ma[3] = a[2]; n1_mb[3] = b[1];
                n1_ma[4] = a[0]; n1_mb[4] = b[2];
                n1_ma[5] = a[1]; n1_mb[5] = b[0];
            end
            default: begin
            end
        endcase
    end

    // stage 2
    logic                 r2_vld;
    logic [2:0]           r2_op;
    logic signed [CW-1:0] r2_vec  [4];
    logic [3:0]           r2_vsat;
    logic signed [PW-1:0] r2_p    [6];
    logic [3:0]           r2_neg;
    logic [3:0][CW-1:0]   r2_mag;

    // stage 3
    logic signed [PW:0]   n3_e    [4];
    logic                 r3_vld;
    logic [2:0]           r3_op;
    logic signed [CW-1:0] r3_vec  [4];
    logic [3:0]           r3_vsat;
    logic signed [PW:0]   r3_e    [4];
    logic [3:0]           r3_neg;
    logic [3:0][CW-1:0]   r3_mag;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n3_e[i] = '0;
        end
        unique case (r2_op)
            v4alu_pkg::OP_SCALE: begin
                for (int i = 0; i < 4; i++) begin
                    n3_e[i] = (PW+1)'(r2_p[i]);
                end
            end
            v4alu_pkg::OP_CROSS: begin
                n3_e[0] = (PW+1)'(r2_p[0]) - (PW+1)'(r2_p[3]);
                n3_e[1] = (PW+1)'(r2_p[1]) - (PW+1)'(r2_p[4]);
                n3_e[2] = (PW+1)'(r2_p[2]) - (PW+1)'(r2_p[5]);
            end
            v4alu_pkg::OP_DOT, v4alu_pkg::OP_LENGTH, v4alu_pkg::OP_NORM: begin
                n3_e[0] = (PW+1)'(r2_p[0]) + (PW+1)'(r2_p[1]);
                n3_e[1] = (PW+1)'(r2_p[2]) + (PW+1)'(r2_p[3]);
            end
            default: begin
            end
        endcase
    end

    // stage 4
    logic signed [PW+1:0] n4_sum;
    logic                 r4_vld;
    logic [2:0]           r4_op;
    logic signed [CW-1:0] r4_vec  [4];
    logic [3:0]           r4_vsat;
    logic signed [PW:0]   r4_e    [4];
    logic signed [PW+1:0] r4_sum;
    logic [3:0]           r4_neg;
    logic [3:0][CW-1:0]   r4_mag;

    assign n4_sum = (PW+2)'(r3_e[0]) + (PW+2)'(r3_e[1]);

    // stage 5
    logic [CW:0]          ts_l    [4];
    logic [CW:0]          ts_s;
    v4alu_pkg::t_pass     n5_pass;
    logic                 r5_vld;
    v4alu_pkg::t_pass     r5_pass;
    logic [PW+1:0]        r5_rad;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ts_l[i] = trunc_sat((PW+2)'(r4_e[i]));
        end
        ts_s = trunc_sat(r4_sum);
    end

    always_comb begin
        n5_pass.op    = r4_op;
        n5_pass.a_neg = r4_neg;
        n5_pass.a_mag = r4_mag;
        n5_pass.res   = '0;
        unique case (r4_op)
            v4alu_pkg::OP_ADD, v4alu_pkg::OP_SUB: begin
                n5_pass.res.r_x       = r4_vec[0];
                n5_pass.res.r_y       = r4_vec[1];
                n5_pass.res.r_z       = r4_vec[2];
                n5_pass.res.r_w       = r4_vec[3];
                n5_pass.res.saturated = |r4_vsat;
            end
            v4alu_pkg::OP_SCALE: begin
                n5_pass.res.r_x       = ts_l[0][CW-1:0];
                n5_pass.res.r_y       = ts_l[1][CW-1:0];
                n5_pass.res.r_z       = ts_l[2][CW-1:0];
                n5_pass.res.r_w       = ts_l[3][CW-1:0];
                n5_pass.res.saturated = ts_l[0][CW] | ts_l[1][CW] | ts_l[2][CW] | ts_l[3][CW];
            end
            v4alu_pkg::OP_CROSS: begin
                n5_pass.res.r_x       = ts_l[0][CW-1:0];
                n5_pass.res.r_y       = ts_l[1][CW-1:0];
                n5_pass.res.r_z       = ts_l[2][CW-1:0];
                n5_pass.res.saturated = ts_l[0][CW] | ts_l[1][CW] | ts_l[2][CW];
            end
            v4alu_pkg::OP_DOT: begin
                n5_pass.res.scalar_result = ts_s[CW-1:0];
                n5_pass.res.saturated     = ts_s[CW];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op   <= i_req.operation;
            r1_vec  <= n1_vec;
            r1_vsat <= n1_vsat;
            r1_ma   <= n1_ma;
            r1_mb   <= n1_mb;
            r1_neg  <= n1_neg;
            r1_mag  <= n1_mag;

            r2_op   <= r1_op;
            r2_vec  <= r1_vec;
            r2_vsat <= r1_vsat;
            r2_neg  <= r1_neg;
            r2_mag  <= r1_mag;
            for (int i = 0; i < 6; i++) begin
                r2_p[i] <= r1_ma[i] * r1_mb[i];
            end

            r3_op   <= r2_op;
            r3_vec  <= r2_vec;
            r3_vsat <= r2_vsat;
            r3_e    <= n3_e;
            r3_neg  <= r2_neg;
            r3_mag  <= r2_mag;

            r4_op   <= r3_op;
            r4_vec  <= r3_vec;
            r4_vsat <= r3_vsat;
            r4_e    <= r3_e;
            r4_sum  <= n4_sum;
            r4_neg  <= r3_neg;
            r4_mag  <= r3_mag;

            r5_pass <= n5_pass;
            r5_rad  <= r4_sum;
        end
    end

    assign o_vld  = r5_vld;
    assign o_pass = r5_pass;
    assign o_rad  = r5_rad;

endmodule

[rtl/v4alu_sqrt.sv]
// ----------------------------------------------------------------------------
// v4alu_sqrt
// Floored integer square root of the sum of squares, one root bit per
// register stage.
// ----------------------------------------------------------------------------
module v4alu_sqrt (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  v4alu_pkg::t_pass                     i_pass,
    input  logic [v4alu_pkg::RAD_W-1:0]          i_rad,
    output logic                                 o_vld,
    output v4alu_pkg::t_pass                     o_pass,
    output logic [v4alu_pkg::SQ_W-1:0]           o_len
);

    localparam int N  = v4alu_pkg::SQ_W;
    localparam int RW = v4alu_pkg::RAD_W;
    localparam int R  = N + 3;

    logic                 s_vld  [N+1];
    logic [RW-1:0]        s_rad  [N+1];
    logic [R-1:0]         s_rem  [N+1];
    logic [N-1:0]         s_root [N+1];
    v4alu_pkg::t_pass     s_pass [N+1];

    assign s_vld[0]  = i_vld;
    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_pass[0] = i_pass;

    genvar k;
    for (k = 0; k < N; k++) begin : g_st
        logic [R-1:0]     n_sh;
        logic [R-1:0]     n_trial;
        logic             n_ge;
        logic             r_vld;
        logic [RW-1:0]    r_rad;
        logic [R-1:0]     r_rem;
        logic [N-1:0]     r_root;
        v4alu_pkg::t_pass r_pass;

        assign n_sh    = {s_rem[k][R-3:0], s_rad[k][RW-1:RW-2]};
        assign n_trial = R'({s_root[k], 2'b01});
        assign n_ge    = n_sh >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad  <= s_rad[k] << 2;
                r_rem  <= n_ge ? (n_sh - n_trial) : n_sh;
                r_root <= {s_root[k][N-2:0], n_ge};
                r_pass <= s_pass[k];
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_rad[k+1]  = r_rad;
        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_pass[k+1] = r_pass;
    end

    assign o_vld  = s_vld[N];
    assign o_pass = s_pass[N];
    assign o_len  = s_root[N];

endmodule

[rtl/v4alu_div.sv]
// ----------------------------------------------------------------------------
// v4alu_div
// Four-lane restoring divider for normalize, one quotient bit per stage,
// followed by the final length/normalize result select and clamp.
// ----------------------------------------------------------------------------
module v4alu_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_vld,
    input  v4alu_pkg::t_pass                     i_pass,
    input  logic [v4alu_pkg::SQ_W-1:0]           i_len,
    output logic                                 o_vld,
    output v4alu_pkg::t_res                      o_res
);

    localparam int CW = v4alu_pkg::CW;
    localparam int N  = v4alu_pkg::SQ_W;
    localparam int L  = v4alu_pkg::Q_W;
    localparam int DR = N + 1;

    function automatic logic [CW:0] norm_lane(input logic neg, input logic [L-1:0] q);
        logic [CW:0]   qx;
        logic [CW:0]   lim;
        logic          sat;
        logic [CW-1:0] m;
        logic [CW-1:0] v;
        qx  = (CW+1)'(q);
        lim = neg ? ((CW+1)'(1) << (CW-1)) : (((CW+1)'(1) << (CW-1)) - 1'b1);
        sat = qx > lim;
        m   = sat ? lim[CW-1:0] : qx[CW-1:0];
        v   = neg ? -m : m;
        return {sat, v};
    endfunction

    logic                 s_vld  [L+1];
    logic [N-1:0]         s_len  [L+1];
    logic [3:0][DR-1:0]   s_rem  [L+1];
    logic [3:0][L-1:0]    s_q    [L+1];
    v4alu_pkg::t_pass     s_pass [L+1];

    assign s_vld[0]  = i_vld;
    assign s_len[0]  = i_len;
    assign s_q[0]    = '0;
    assign s_pass[0] = i_pass;

    genvar j, k;
    for (j = 0; j < 4; j++) begin : g_init
        assign s_rem[0][j] = DR'(i_pass.a_mag[j] >> 1);
    end

    for (k = 0; k < L; k++) begin : g_st
        logic [3:0][DR-1:0] n_rem;
        logic [3:0][L-1:0]  n_q;
        logic               r_vld;
        logic [N-1:0]       r_len;
        logic [3:0][DR-1:0] r_rem;
        logic [3:0][L-1:0]  r_q;
        v4alu_pkg::t_pass   r_pass;

        for (j = 0; j < 4; j++) begin : g_lane
            logic [DR-1:0] n_sh;
            logic          n_ge;
            assign n_sh = {s_rem[k][j][DR-2:0],
                           (k == 0) ? s_pass[k].a_mag[j][0] : 1'b0};
            assign n_ge = n_sh >= DR'(s_len[k]);
            assign n_rem[j] = n_ge ? (n_sh - DR'(s_len[k])) : n_sh;
            assign n_q[j]   = {s_q[k][j][L-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len  <= s_len[k];
                r_rem  <= n_rem;
                r_q    <= n_q;
                r_pass <= s_pass[k];
            end
        end

        assign s_vld[k+1]  = r_vld;
        assign s_len[k+1]  = r_len;
        assign s_rem[k+1]  = r_rem;
        assign s_q[k+1]    = r_q;
        assign s_pass[k+1] = r_pass;
    end

    v4alu_pkg::t_pass    f_pass;
    logic [N-1:0]        f_len;
    logic [CW:0]         f_lane [4];
    logic                f_lsat;

    assign f_pass = s_pass[L];
    assign f_len  = s_len[L];
    assign f_lsat = f_len > N'({1'b0, {(CW-1){1'b1}}});

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            f_lane[i] = norm_lane(f_pass.a_neg[i], s_q[L][i]);
        end
    end

    always_comb begin
        o_res = f_pass.res;
        priority if ((f_pass.op == v4alu_pkg::OP_LENGTH || f_pass.op == v4alu_pkg::OP_NORM)
                     && f_len == '0) begin
            o_res.zero_length = 1'b1;
        end else if (f_pass.op == v4alu_pkg::OP_LENGTH) begin
            o_res.scalar_result = f_lsat ? {1'b0, {(CW-1){1'b1}}} : f_len[CW-1:0];
            o_res.saturated     = f_lsat;
        end else if (f_pass.op == v4alu_pkg::OP_NORM) begin
            o_res.r_x       = f_lane[0][CW-1:0];
            o_res.r_y       = f_lane[1][CW-1:0];
            o_res.r_z       = f_lane[2][CW-1:0];
            o_res.r_w       = f_lane[3][CW-1:0];
            o_res.saturated = f_lane[0][CW] | f_lane[1][CW] | f_lane[2][CW] | f_lane[3][CW];
        end else begin
        end
    end

    assign o_vld = s_vld[L];

endmodule

[rtl/vec4_vector_alu_core.sv]
// ----------------------------------------------------------------------------
// vec4_vector_alu_core
// Four-component Q16.16 vector unit: add, subtract, scale, dot, cross,
// length and normalize, with saturation and zero-length flags.
// ----------------------------------------------------------------------------
// Takes one request every clock while o_ready is high and returns one result
// per request, in order. The accepting edge loads the first of 57 register
// stages: an input register, five stages of operand select, multiply, product
// sums and clamp, a 33-stage square root that makes one root bit per stage,
// a 17-stage divider that makes one quotient bit per stage in each of four
// lanes, and the output register. A stall at the output freezes the whole
// pipeline only once a one-entry skid buffer behind the output register is
// full, so a result waiting to be taken does not block the next request.
module vec4_vector_alu_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  v4alu_pkg::t_req    i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output v4alu_pkg::t_res    o_res
);

    logic                              adv;
    logic                              take;
    logic                              done;
    logic                              r_vld0;
    v4alu_pkg::t_req                   r_req0;
    logic                              f_vld;
    v4alu_pkg::t_pass                  f_pass;
    logic [v4alu_pkg::RAD_W-1:0]       f_rad;
    logic                              q_vld;
    v4alu_pkg::t_pass                  q_pass;
    logic [v4alu_pkg::SQ_W-1:0]        q_len;
    logic                              d_vld;
    v4alu_pkg::t_res                   d_res;
    logic                              r_ovld;
    v4alu_pkg::t_res                   r_ores;
    logic                              r_skid_vld;
    v4alu_pkg::t_res                   r_skid;

    assign adv     = !r_skid_vld;
    assign take    = !r_ovld || i_ready;
    assign done    = d_vld && adv;
    assign o_ready = adv;

    v4alu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_vld0),
        .i_req   (r_req0),
        .o_vld   (f_vld),
        .o_pass  (f_pass),
        .o_rad   (f_rad)
    );

    v4alu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (f_vld),
        .i_pass  (f_pass),
        .i_rad   (f_rad),
        .o_vld   (q_vld),
        .o_pass  (q_pass),
        .o_len   (q_len)
    );

    v4alu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (q_vld),
        .i_pass  (q_pass),
        .i_len   (q_len),
        .o_vld   (d_vld),
        .o_res   (d_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0     <= 1'b0;
            r_ovld     <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (adv) begin
                r_vld0 <= i_valid;
            end
            if (take) begin
                if (r_skid_vld) begin
                    r_ovld     <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_ovld <= done;
                end
            end else if (done) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req0 <= i_req;
        end
        if (take) begin
            r_ores <= r_skid_vld ? r_skid : d_res;
        end else if (done) begin
            r_skid <= d_res;
        end
    end

    assign o_valid = r_ovld;
    assign o_res   = r_ores;

endmodule

[rtl/v4alu_chk.sv]
// ----------------------------------------------------------------------------
// v4alu_chk
// Port-level checks for the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module v4alu_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input v4alu_pkg::t_req   i_req,
    input logic              o_valid,
    input logic              i_ready,
    input v4alu_pkg::t_res   o_res
);

    // held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res))
        else $error("result changed while stalled");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // request side only blocks behind a stalled result
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> $past(o_valid && !i_ready))
        else $error("request blocked without output stall");

    // zero-length vector gives all-zero outputs
    a_zl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.zero_length |-> o_res.r_x == '0 && o_res.r_y == '0 &&
            o_res.r_z == '0 && o_res.r_w == '0 && o_res.scalar_result == '0 &&
            !o_res.saturated)
        else $error("zero-length result not clean");

endmodule

bind vec4_vector_alu_core v4alu_chk u_chk (.*);

[tb/vec4_alu_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vec4_alu_checker
// Watches the request and result channels of the vector unit, predicts each
// result from the accepted request and compares it field by field in order.
// ----------------------------------------------------------------------------
module vec4_alu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_o_ready,
    input  v4alu_pkg::t_req    i_req,
    input  logic               i_o_valid,
    input  logic               i_ready,
    input  v4alu_pkg::t_res    i_res,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);
    import v4alu_pkg::*;

    localparam logic signed [127:0] MAX_CODE = 128'sd2147483647;
    localparam logic signed [127:0] MIN_CODE = -128'sd2147483648;

    t_res expected_results[$];

    function automatic logic [CW-1:0] clamp_code(input logic signed [127:0] v,
                                                  inout logic sat);
        if (v > MAX_CODE) begin
            sat = 1'b1;
            return MAX_CODE[CW-1:0];
        end
        if (v < MIN_CODE) begin
            sat = 1'b1;
            return MIN_CODE[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    // signed shift right truncating toward zero
    function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
        logic [127:0] m;
        m = (v < 0) ? -v : v;
        m = m >> FB;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [127:0] isqrt(input logic [127:0] s);
        logic [127:0] lo, hi, mid;
        lo = 0;
        hi = 128'd1 << 34;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= s) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic t_res predict_vector_op(input t_req q);
        logic signed [127:0] a[4], b[4], r[4], sc, s;
        logic [127:0] sum, len, m;
        logic sat;
        t_res res;
        a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z; a[3] = q.a_w;
        b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z; b[3] = q.b_w;
        s = q.scale_factor;
        sat = 1'b0;
        sc = 0;
        res = '0;
        for (int i = 0; i < 4; i++) r[i] = 0;
        case (q.operation)
            OP_ADD:   for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
            OP_SUB:   for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
            OP_SCALE: for (int i = 0; i < 4; i++) r[i] = drop_frac(a[i] * s);
            OP_DOT: begin
                for (int i = 0; i < 4; i++) sc = sc + a[i] * b[i];
                sc = drop_frac(sc);
            end
            OP_CROSS: begin
                r[0] = drop_frac(a[1] * b[2] - a[2] * b[1]);
                r[1] = drop_frac(a[2] * b[0] - a[0] * b[2]);
                r[2] = drop_frac(a[0] * b[1] - a[1] * b[0]);
            end
            OP_LENGTH, OP_NORM: begin
                sum = 0;
                for (int i = 0; i < 4; i++) sum = sum + a[i] * a[i];
                len = isqrt(sum);
                if (len == 0) begin
                    res.zero_length = 1'b1;
                end else if (q.operation == OP_LENGTH) begin
                    sc = len;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        m = (a[i] < 0) ? -a[i] : a[i];
                        m = (m << FB) / len;
                        r[i] = (a[i] < 0) ? -$signed(m) : $signed(m);
                    end
                end
            end
            default: ;
        endcase
        res.r_x = clamp_code(r[0], sat);
        res.r_y = clamp_code(r[1], sat);
        res.r_z = clamp_code(r[2], sat);
        res.r_w = clamp_code(r[3], sat);
        res.scalar_result = clamp_code(sc, sat);
        res.saturated = sat;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        if (!i_rst_n) begin
            o_errors  <= 0;
            o_results <= 0;
            expected_results.delete();
        end else begin
            if (i_valid && i_o_ready) expected_results.push_back(predict_vector_op(i_req));
            if (i_o_valid && i_ready) begin
                o_results <= o_results + 1;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e !== i_res) begin
                        o_errors <= o_errors + 1;
                        if (e.r_x !== i_res.r_x)
                            $error("r_x exp %h got %h", e.r_x, i_res.r_x);
                        if (e.r_y !== i_res.r_y)
                            $error("r_y exp %h got %h", e.r_y, i_res.r_y);
                        if (e.r_z !== i_res.r_z)
                            $error("r_z exp %h got %h", e.r_z, i_res.r_z);
                        if (e.r_w !== i_res.r_w)
                            $error("r_w exp %h got %h", e.r_w, i_res.r_w);
                        if (e.scalar_result !== i_res.scalar_result)
                            $error("scalar_result exp %h got %h",
                                   e.scalar_result, i_res.scalar_result);
                        if (e.saturated !== i_res.saturated)
                            $error("saturated exp %b got %b", e.saturated, i_res.saturated);
                        if (e.zero_length !== i_res.zero_length)
                            $error("zero_length exp %b got %b",
                                   e.zero_length, i_res.zero_length);
                    end
                end
            end
        end
    end

    assign o_pending = expected_results.size();

endmodule

[tb/tb_vec4_vector_alu_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vec4_vector_alu_core
// Drives directed and random vector requests with random idle bursts on both
// channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_vec4_vector_alu_core;
    import v4alu_pkg::*;

    localparam int N_RANDOM  = 600;
    localparam int LATENCY   = 57;
    localparam int MAX_CYCLE = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    t_req i_req = '0;
    t_res o_res;
    int   errors, pending, results;
    int   cycle = 0;
    int   n_sent = 0;
    logic idle_off = 1'b0;

    vec4_vector_alu_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

    vec4_alu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_ready(o_ready),
        .i_req(i_req), .i_o_valid(o_valid), .i_ready(i_ready), .i_res(o_res),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= MAX_CYCLE) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side stalls in bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 15);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [CW-1:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_req q);
        i_valid <= 1'b1;
        i_req   <= q;
        do @(posedge i_clk); while (!o_ready);
        n_sent++;
        if (!idle_off && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic t_req make_request(input logic [2:0] op, input logic [CW-1:0] v);
        t_req q;
        q.operation = op;
        q.a_x = v; q.a_y = v; q.a_z = v; q.a_w = v;
        q.b_x = v; q.b_y = v; q.b_z = v; q.b_w = v;
        q.scale_factor = v;
        return q;
    endfunction

    initial begin
        t_req q;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // codes 0 to 7 at all-max and all-min, codes 5 to 7 also at zero
        for (int op = 0; op < 8; op++) begin
            send_request(make_request(op[2:0], 32'h7fffffff));
            send_request(make_request(op[2:0], 32'h80000000));
            if (op >= OP_LENGTH) send_request(make_request(op[2:0], '0));
        end
        q = make_request(OP_NORM, '0);
        q.a_z = 32'h00000001;
        send_request(q);
        q.operation = OP_CROSS;
        q.a_x = 32'h00010000; q.b_y = 32'h00010000; q.a_z = '0;
        send_request(q);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 100) idle_off = 1'b1;
            q.operation = $urandom_range(0, 9) == 0 ? 3'd7 : 3'($urandom_range(0, 6));
            q.a_x = pick_comp(); q.a_y = pick_comp();
            q.a_z = pick_comp(); q.a_w = pick_comp();
            q.b_x = pick_comp(); q.b_y = pick_comp();
            q.b_z = pick_comp(); q.b_w = pick_comp();
            q.scale_factor = pick_comp();
            send_request(q);
        end
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("sent %0d requests over all seven operations and the spare code", n_sent);
        $display("checked %0d results with random stalls on both channels", results);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
